// ----- sv/hzs_pkg.sv -----
// Shared constants, command codes and decode helpers for the heater zone sequencer.
package hzs_pkg;

  // Zone count default and the number of zones shown in the result masks
  localparam int ZONES_DEF   = 4;
  localparam int MASK_W      = 4;

  // Field widths
  localparam int TIME_W      = 32;
  localparam int CMD_W       = 8;
  localparam int TEMP_W      = 8;
  localparam int IVAL_W      = 16;
  localparam int THR_W       = 5;
  localparam int CHOICE_W    = 2;

  // Stream and configuration port widths
  localparam int S_DATA_W    = 64;
  localparam int M_DATA_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_SHORT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MEDIUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LONG   = 2'd2;

  // Configuration reset values
  localparam logic [IVAL_W-1:0] IVAL_SHORT_RST  = 16'd5000;
  localparam logic [IVAL_W-1:0] IVAL_MEDIUM_RST = 16'd10000;
  localparam logic [IVAL_W-1:0] IVAL_LONG_RST   = 16'd15000;

  // Interval choice codes
  localparam logic [CHOICE_W-1:0] CHOICE_SHORT  = 2'd0;
  localparam logic [CHOICE_W-1:0] CHOICE_MEDIUM = 2'd1;

  // Threshold range
  localparam logic [THR_W-1:0] THR_BASE = 5'd25;

  // Command bytes
  localparam logic [CMD_W-1:0] CMD_ZONE_FIRST = 8'h30;  // '0'
  localparam logic [CMD_W-1:0] CMD_ZONE_LAST  = 8'h37;  // '7'
  localparam logic [CMD_W-1:0] CMD_ALL_ON     = 8'h38;  // '8'
  localparam logic [CMD_W-1:0] CMD_ALL_OFF    = 8'h39;  // '9'
  localparam logic [CMD_W-1:0] CMD_AUTO_ON    = 8'h4B;  // 'K'
  localparam logic [CMD_W-1:0] CMD_AUTO_OFF   = 8'h4C;  // 'L'
  localparam logic [CMD_W-1:0] CMD_IVAL_FIRST = 8'h41;  // 'A'
  localparam logic [CMD_W-1:0] CMD_IVAL_LAST  = 8'h43;  // 'C'
  localparam logic [CMD_W-1:0] CMD_THR_FIRST  = 8'h44;  // 'D'
  localparam logic [CMD_W-1:0] CMD_THR_LAST   = 8'h49;  // 'I'

  // Digit commands: which zone a digit addresses
  function automatic logic [1:0] digit_zone(input logic [2:0] d);
    logic [1:0] z;
    z = d[2:1];
    return z;
  endfunction

  // Digit commands: on or off ('1','2','4','6' turn on; the rest turn off)
  function automatic logic digit_on(input logic [2:0] d);
    logic on;
    case (d)
      3'd1, 3'd2, 3'd4, 3'd6: on = 1'b1;
      default:                on = 1'b0;
    endcase
    return on;
  endfunction

endpackage

// ----- sv/heater_zone_sequencer.sv -----
// Heater zone sequencer: command decode, auto rule and round-robin relay timing.
//
// An accepted item is held in the input register; one pass of logic then loads the
// result register when that has room, and its result is offered from there.
// Throughput: one item per cycle; the input register refills on the same edge
// the result register loads, so the only stall is m_tready low.
// Reset (rst, synchronous, active high): zones disabled, relays off, toggle
// times zero, short interval, threshold zero, auto off, intervals 5000/10000/15000.
module heater_zone_sequencer
  #(parameter int ZONES = hzs_pkg::ZONES_DEF)
  (
    input  logic                            clk,
    input  logic                            rst,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms[31:0], cmd_valid[32], cmd_byte[40:33], temp_inside[48:41],
    // temp_outside[56:49], button_press[57], button_double[58], zero[63:59]
    input  logic [hzs_pkg::S_DATA_W-1:0]    s_tdata,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // relay_mask[3:0], enable_mask[7:4], auto_on[8], zero[15:9]
    output logic [hzs_pkg::M_DATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [hzs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hzs_pkg::CFG_DATA_W-1:0]  cfg_data
  );
  import hzs_pkg::*;

  // zones that appear in the masks
  localparam int SHOWN = (ZONES < MASK_W) ? ZONES : MASK_W;

  // ---------------- configuration registers ----------------
  logic [IVAL_W-1:0] interval_short, interval_medium, interval_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_short  <= IVAL_SHORT_RST;
      interval_medium <= IVAL_MEDIUM_RST;
      interval_long   <= IVAL_LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL_SHORT:  interval_short  <= cfg_data;
        REG_INTERVAL_MEDIUM: interval_medium <= cfg_data;
        REG_INTERVAL_LONG:   interval_long   <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------- handshake / pipeline control ----------------
  logic                in_full;
  logic [S_DATA_W-1:0] in_data;
  logic                advance;

  // the held item moves into the result register when that has room
  assign advance  = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  // unpack the held item
  logic [TIME_W-1:0] now_ms;
  logic              cmd_valid;
  logic [CMD_W-1:0]  cmd_byte;
  logic [TEMP_W-1:0] temp_inside, temp_outside;
  logic              button_press, button_double;

  assign now_ms        = in_data[31:0];
  assign cmd_valid     = in_data[32];
  assign cmd_byte      = in_data[40:33];
  assign temp_inside   = in_data[48:41];
  assign temp_outside  = in_data[56:49];
  assign button_press  = in_data[57];
  assign button_double = in_data[58];

  // ---------------- controller state ----------------
  logic [ZONES-1:0]    zone_enable, zone_enable_next;
  logic [ZONES-1:0]    relay_on, relay_on_next;
  logic [TIME_W-1:0]   last_toggle [ZONES];
  logic [TIME_W-1:0]   last_toggle_next [ZONES];
  logic [CHOICE_W-1:0] interval_choice, interval_choice_next;
  logic [THR_W-1:0]    threshold, threshold_next;
  logic                auto_mode, auto_mode_next;

  // per-zone timer expiry; independent of the relay chain
  logic [CHOICE_W-1:0] choice_now;
  logic [IVAL_W-1:0]   interval_sel;
  logic [ZONES-1:0]    due;

  // an interval command in this item takes effect in the same pass
  always_comb begin
    choice_now = interval_choice;
    if (cmd_valid && cmd_byte >= CMD_IVAL_FIRST && cmd_byte <= CMD_IVAL_LAST) begin
      choice_now = CHOICE_W'(cmd_byte - CMD_IVAL_FIRST);
    end
  end

  always_comb begin
    case (choice_now)
      CHOICE_SHORT:  interval_sel = interval_short;
      CHOICE_MEDIUM: interval_sel = interval_medium;
      default:       interval_sel = interval_long;
    endcase
  end

  always_comb begin
    for (int i = 0; i < ZONES; i++) begin
      // modulo 2^32 elapsed time
      due[i] = (now_ms - last_toggle[i]) >= {{(TIME_W-IVAL_W){1'b0}}, interval_sel};
    end
  end

  // one control pass: command, auto rule, zones in order, then buttons
  logic [2:0]        digit;
  logic [1:0]        dzone;
  logic              thr_lo_i, thr_lo_o, thr_hi_i, thr_hi_o;
  logic [ZONES-1:0]  others_mask;

  always_comb begin
    zone_enable_next     = zone_enable;
    relay_on_next        = relay_on;
    last_toggle_next     = last_toggle;
    interval_choice_next = interval_choice;
    threshold_next       = threshold;
    auto_mode_next       = auto_mode;
    digit                = cmd_byte[2:0];
    dzone                = digit_zone(digit);
    others_mask          = '0;

    if (cmd_valid) begin
      if (cmd_byte >= CMD_ZONE_FIRST && cmd_byte <= CMD_ZONE_LAST) begin
        // zones not built are ignored
        for (int i = 0; i < ZONES; i++) begin
          if (int'(dzone) == i) begin
            zone_enable_next[i] = digit_on(digit);
            if (!digit_on(digit)) begin
              relay_on_next[i] = 1'b0;
            end
          end
        end
      end else if (cmd_byte == CMD_ALL_ON) begin
        zone_enable_next = '1;
      end else if (cmd_byte == CMD_ALL_OFF) begin
        zone_enable_next = '0;
        relay_on_next    = '0;
      end else if (cmd_byte == CMD_AUTO_ON) begin
        auto_mode_next = 1'b1;
      end else if (cmd_byte == CMD_AUTO_OFF) begin
        auto_mode_next   = 1'b0;
        zone_enable_next = '0;
        relay_on_next    = '0;
      end else if (cmd_byte >= CMD_IVAL_FIRST && cmd_byte <= CMD_IVAL_LAST) begin
        interval_choice_next = CHOICE_W'(cmd_byte - CMD_IVAL_FIRST);
      end else if (cmd_byte >= CMD_THR_FIRST && cmd_byte <= CMD_THR_LAST) begin
        threshold_next = THR_BASE + THR_W'(cmd_byte - CMD_THR_FIRST);
      end
    end

    // auto rule; a temperature equal to the threshold blocks both actions
    thr_lo_i = temp_inside  < TEMP_W'(threshold_next);
    thr_lo_o = temp_outside < TEMP_W'(threshold_next);
    thr_hi_i = temp_inside  > TEMP_W'(threshold_next);
    thr_hi_o = temp_outside > TEMP_W'(threshold_next);
    if (auto_mode_next) begin
      if (thr_lo_i && thr_lo_o) begin
        zone_enable_next = '1;
      end
      if ((thr_hi_i && thr_lo_o) || (thr_hi_i && thr_hi_o) || (thr_lo_i && thr_hi_o)) begin
        zone_enable_next = '0;
        relay_on_next    = '0;
      end
    end

    // round robin: each zone sees the relays as left by the zones before it
    for (int i = 0; i < ZONES; i++) begin
      others_mask = relay_on_next & ~(ZONES'(1) << i);
      if (zone_enable_next[i] && !(|others_mask) && due[i]) begin
        last_toggle_next[i] = now_ms;
        relay_on_next[i]    = !relay_on_next[i];
      end
    end

    if (button_press) begin
      zone_enable_next = '1;
    end
    if (button_double) begin
      zone_enable_next = '0;
      relay_on_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_enable     <= '0;
      relay_on        <= '0;
      interval_choice <= CHOICE_SHORT;
      threshold       <= '0;
      auto_mode       <= 1'b0;
      for (int i = 0; i < ZONES; i++) begin
        last_toggle[i] <= '0;
      end
    end else if (advance) begin
      zone_enable     <= zone_enable_next;
      relay_on        <= relay_on_next;
      interval_choice <= interval_choice_next;
      threshold       <= threshold_next;
      auto_mode       <= auto_mode_next;
      last_toggle     <= last_toggle_next;
    end
  end

  // ---------------- result register ----------------
  logic [MASK_W-1:0] relay_mask, enable_mask;

  always_comb begin
    relay_mask  = '0;
    enable_mask = '0;
    for (int i = 0; i < SHOWN; i++) begin
      relay_mask[i]  = relay_on_next[i];
      enable_mask[i] = zone_enable_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(M_DATA_W-2*MASK_W-1){1'b0}}, auto_mode_next, enable_mask, relay_mask};
    end
  end

  // ---------------- assertions ----------------
  // round robin: never more than one relay on
  a_one_relay: assert property (@(posedge clk) disable iff (rst) $onehot0(relay_on))
    else $error("more than one relay on");

  // a relay is only on for an enabled zone
  a_relay_enabled: assert property (@(posedge clk) disable iff (rst)
    (relay_on & ~zone_enable) == '0)
    else $error("relay on for a disabled zone");

  // threshold is zero or within the command range
  a_thr_range: assert property (@(posedge clk) disable iff (rst)
    threshold == '0 || (threshold >= THR_BASE && threshold <= THR_BASE + THR_W'(5)))
    else $error("threshold out of range");

  // a held item with a stalled result stays held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && m_tvalid && !m_tready |=> in_full && $stable(in_data))
    else $error("held item lost while stalled");

endmodule
